@@ sv/uap_pkg.sv @@
// ----------------------------------------------------------------------------
// uap_pkg
// Shared types and constants for the username/password request parser.
// ----------------------------------------------------------------------------
package uap_pkg;

  // Longest user or password field accepted, in bytes (1 to 255)
  localparam logic [7:0] FIELD_LEN_MAX = 8'd255;

  localparam logic [7:0] AUTH_VERSION = 8'h01;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_ULEN    = 3'd1,
    PH_USER    = 3'd2,
    PH_PLEN    = 3'd3,
    PH_PASS    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] field_kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       last_in_field;
  } result_t;

  // Parser state flags exported for checking
  typedef struct packed {
    logic done;
    logic error;
  } flags_t;

endpackage

@@ sv/uap_in_stage.sv @@
// ----------------------------------------------------------------------------
// uap_in_stage
// Input register: captures one request item and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module uap_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  output logic       s_valid,
  input  logic       s_ready,
  output logic       s_req_type,
  output logic [7:0] s_data_byte
);
  import uap_pkg::*;

  logic       full;
  logic       req_type_q;
  logic [7:0] data_byte_q;

  // Take a new item when empty or when the held one leaves this cycle
  assign in_ready = !full || s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_ready && in_valid) begin
      req_type_q  <= req_type;
      data_byte_q <= data_byte;
    end
  end

  assign s_valid     = full;
  assign s_req_type  = req_type_q;
  assign s_data_byte = data_byte_q;

endmodule

@@ sv/uap_core.sv @@
// ----------------------------------------------------------------------------
// uap_core
// Parser state and single-step decode: forms the result for the held item
// and advances the state when that item moves on.
// ----------------------------------------------------------------------------
module uap_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             req_type,
  input  logic [7:0]       data_byte,
  output uap_pkg::result_t result,
  output uap_pkg::flags_t  flags
);
  import uap_pkg::*;

  phase_t     phase, phase_next;
  logic       done_flag, done_flag_next;
  logic       error_flag, error_flag_next;
  logic [7:0] user_length, user_length_next;
  logic [7:0] pass_length, pass_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;

  logic       len_ok;
  logic [8:0] seen_inc;
  logic       user_last;
  logic       pass_last;

  assign len_ok    = (data_byte != 8'd0) && (data_byte <= FIELD_LEN_MAX);
  assign seen_inc  = {1'b0, bytes_seen} + 9'd1;
  assign user_last = seen_inc >= {1'b0, user_length};
  assign pass_last = seen_inc >= {1'b0, pass_length};

  always_comb begin
    phase_next       = phase;
    done_flag_next   = done_flag;
    error_flag_next  = error_flag;
    user_length_next = user_length;
    pass_length_next = pass_length;
    bytes_seen_next  = bytes_seen;
    result.status        = ST_MORE;
    result.field_kind    = 3'(PH_VERSION);
    result.byte_value    = data_byte;
    result.byte_index    = 8'd0;
    result.last_in_field = 1'b0;

    if (req_type) begin
      phase_next       = PH_VERSION;
      done_flag_next   = 1'b0;
      error_flag_next  = 1'b0;
      user_length_next = 8'd0;
      pass_length_next = 8'd0;
      bytes_seen_next  = 8'd0;
      result.byte_value = 8'd0;
    end else if (error_flag) begin
      result.status = ST_ERROR;
    end else if (done_flag) begin
      result.status = ST_DONE;
    end else begin
      case (phase)
        PH_VERSION: begin
          result.field_kind = 3'(PH_VERSION);
          if (data_byte != AUTH_VERSION) begin
            error_flag_next = 1'b1;
            result.status   = ST_ERROR;
          end else begin
            phase_next = PH_ULEN;
          end
        end
        PH_ULEN: begin
          result.field_kind = 3'(PH_ULEN);
          if (!len_ok) begin
            error_flag_next = 1'b1;
            result.status   = ST_ERROR;
          end else begin
            user_length_next = data_byte;
            bytes_seen_next  = 8'd0;
            phase_next       = PH_USER;
          end
        end
        PH_USER: begin
          result.field_kind    = 3'(PH_USER);
          result.byte_index    = bytes_seen;
          result.last_in_field = user_last;
          if (user_last) begin
            bytes_seen_next = 8'd0;
            phase_next      = PH_PLEN;
          end else begin
            bytes_seen_next = seen_inc[7:0];
          end
        end
        PH_PLEN: begin
          result.field_kind = 3'(PH_PLEN);
          if (!len_ok) begin
            error_flag_next = 1'b1;
            result.status   = ST_ERROR;
          end else begin
            pass_length_next = data_byte;
            bytes_seen_next  = 8'd0;
            phase_next       = PH_PASS;
          end
        end
        PH_PASS: begin
          result.field_kind    = 3'(PH_PASS);
          result.byte_index    = bytes_seen;
          result.last_in_field = pass_last;
          bytes_seen_next      = seen_inc[7:0];
          if (pass_last) begin
            done_flag_next = 1'b1;
            result.status  = ST_DONE;
          end
        end
        default: begin
          error_flag_next = 1'b1;
          result.status   = ST_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_VERSION;
      done_flag   <= 1'b0;
      error_flag  <= 1'b0;
      user_length <= 8'd0;
      pass_length <= 8'd0;
      bytes_seen  <= 8'd0;
    end else if (advance) begin
      phase       <= phase_next;
      done_flag   <= done_flag_next;
      error_flag  <= error_flag_next;
      user_length <= user_length_next;
      pass_length <= pass_length_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

  assign flags.done  = done_flag;
  assign flags.error = error_flag;

endmodule

@@ sv/userpass_auth_request_parser_unit.sv @@
// An accepted item passes the input register, then the result register.
// Throughput: 1 item per cycle while the output is not stalled (out_ready).
// Reset (rst, synchronous): empties both registers, parser awaits version.
// ----------------------------------------------------------------------------
// userpass_auth_request_parser_unit
// Username/password authentication request parser: one byte per item,
// tagged result per byte, sticky done and error until a restart item.
// ----------------------------------------------------------------------------
module userpass_auth_request_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] field_kind,
  output logic [7:0] byte_value,
  output logic [7:0] byte_index,
  output logic       last_in_field
);
  import uap_pkg::*;

  logic       s_valid;
  logic       s_ready;
  logic       s_req_type;
  logic [7:0] s_data_byte;
  logic       advance;
  result_t    result;
  result_t    result_q;
  flags_t     flags;

  uap_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_req_type  (s_req_type),
    .s_data_byte (s_data_byte)
  );

  // Result register frees up when empty or when the output item is taken
  assign s_ready = !out_valid || out_ready;
  assign advance = s_valid && s_ready;

  uap_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .req_type  (s_req_type),
    .data_byte (s_data_byte),
    .result    (result),
    .flags     (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_ready) begin
      out_valid <= s_valid;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  assign status        = result_q.status;
  assign field_kind    = result_q.field_kind;
  assign byte_value    = result_q.byte_value;
  assign byte_index    = result_q.byte_index;
  assign last_in_field = result_q.last_in_field;

`ifndef NO_ASSERTIONS
  // Done and error are never set together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(flags.done && flags.error))
    else $error("done and error flags both set");

  // Last-of-field only tags user or password bytes
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_in_field) |->
      (field_kind == 3'(PH_USER) || field_kind == 3'(PH_PASS)))
    else $error("last_in_field on a non-data field");

  // A completing password byte always closes its field
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DONE && field_kind == 3'(PH_PASS)) |-> last_in_field)
    else $error("request complete without final password byte");

  // Once complete, the done flag holds until a restart moves through
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (flags.done && !(advance && s_req_type)) |=> flags.done)
    else $error("done flag dropped without restart");
`endif

endmodule
